// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros for the key press classifier.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KPDC_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define KPDC_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/core/kpdc_pkg.sv -----
// Shared types and constants of the key press classifier.
// No dependencies; imported by every module of the block.
package kpdc_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 2;

  // action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // clear type bits
  localparam int CLR_SHORT = 0;
  localparam int CLR_LONG  = 1;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_SHORT_LOW  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SHORT_HIGH = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_LONG_LOW   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_LONG_HIGH  = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    count_t short_low;
    count_t short_high;
    count_t long_low;
    count_t long_high;
  } window_cfg_t;

  typedef struct packed {
    logic       upd;
    logic       action;
    logic [1:0] clear_types;
  } key_ctrl_t;

endpackage

// ----- rtl/core/kpdc_cfg.sv -----
// Window bound registers of the key press classifier.
// Depends on kpdc_pkg.
module kpdc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpdc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [kpdc_pkg::CFG_BITS-1:0] cfg_data,
  output kpdc_pkg::window_cfg_t         win
);
  import kpdc_pkg::*;

  window_cfg_t win_q;

  assign cfg_ready = 1'b1;
  assign win       = win_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_q.short_low  <= COUNT_BITS'(2);
      win_q.short_high <= COUNT_BITS'(500);
      win_q.long_low   <= COUNT_BITS'(1000);
      win_q.long_high  <= COUNT_BITS'(1100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHORT_LOW:  win_q.short_low  <= cfg_data;
        REG_SHORT_HIGH: win_q.short_high <= cfg_data;
        REG_LONG_LOW:   win_q.long_low   <= cfg_data;
        REG_LONG_HIGH:  win_q.long_high  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/kpdc_key.sv -----
// Per-key press state: level history, two saturating counters, sticky flags.
// Depends on kpdc_pkg and assert_macros.svh.
module kpdc_key (
  input  logic                  clk,
  input  logic                  rst,
  input  kpdc_pkg::key_ctrl_t   ctrl,
  input  logic                  level,
  input  logic                  clr_sel,
  input  kpdc_pkg::window_cfg_t win,
  output logic                  short_flag,
  output logic                  long_flag
);
  import kpdc_pkg::*;
  `include "assert_macros.svh"

  logic   last_level, last_level_next;
  logic   sflag, sflag_next;
  logic   lflag, lflag_next;
  count_t short_count, short_count_next;
  count_t long_count, long_count_next;
  count_t short_inc, long_inc;

  assign short_inc = (short_count == COUNT_MAX) ? short_count : short_count + 1'b1;
  assign long_inc  = (long_count == COUNT_MAX) ? long_count : long_count + 1'b1;

  always_comb begin
    last_level_next  = last_level;
    sflag_next       = sflag;
    lflag_next       = lflag;
    short_count_next = short_count;
    long_count_next  = long_count;
    if (ctrl.action == ACT_TICK) begin
      unique case ({last_level, level})
        2'b01: begin
          // release: short window is tested on the count reached while held
          if (win.short_low < short_count && short_count < win.short_high && !lflag)
            sflag_next = 1'b1;
          short_count_next = '0;
        end
        2'b10: short_count_next = '0;
        2'b00: begin
          short_count_next = short_inc;
          long_count_next  = long_inc;
          if (win.long_low < long_inc && long_inc < win.long_high && !sflag) begin
            lflag_next      = 1'b1;
            long_count_next = '0;
          end
        end
        default: begin
          short_count_next = '0;
          long_count_next  = '0;
        end
      endcase
      last_level_next = level;
    end else if (clr_sel) begin
      if (ctrl.clear_types[CLR_SHORT]) begin
        sflag_next       = 1'b0;
        short_count_next = '0;
        last_level_next  = 1'b1;
      end
      if (ctrl.clear_types[CLR_LONG]) begin
        lflag_next      = 1'b0;
        long_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b1;
      sflag       <= 1'b0;
      lflag       <= 1'b0;
      short_count <= '0;
      long_count  <= '0;
    end else if (ctrl.upd) begin
      last_level  <= last_level_next;
      sflag       <= sflag_next;
      lflag       <= lflag_next;
      short_count <= short_count_next;
      long_count  <= long_count_next;
    end
  end

  assign short_flag = sflag;
  assign long_flag  = lflag;

  `KPDC_ASSERT_NXT(a_hold_when_idle, clk, rst, !ctrl.upd,
                   $stable(sflag) && $stable(lflag) && $stable(long_count))
  `KPDC_ASSERT_IMP(a_short_excl_long, clk, rst, $rose(sflag), !lflag)
  `KPDC_ASSERT_IMP(a_long_excl_short, clk, rst, $rose(lflag), !sflag)
  `KPDC_ASSERT_IMP(a_long_restart, clk, rst, $rose(lflag), long_count == '0)

endmodule

// ----- rtl/core/key_press_duration_classifier_unit.sv -----
// Top level of the key press classifier: input register, key lanes, result valid.
// Depends on kpdc_pkg, kpdc_cfg, kpdc_key and assert_macros.svh.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  in       | request   | in_valid / in_stall  | action, pin_levels, clear_keys,
//           |           |                      | clear_types
//  out      | result    | out_valid / out_stall| short_flags, long_flags
//  cfg      | write     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request is taken into the input register; when it advances, all key lanes
// update at once and the flags appear with out_valid: one request per cycle
// sustained unless an output stall holds it. The flags are the lane flag registers themselves.
// Synchronous reset returns the window bounds to their defaults and all keys to
// released with cleared counts and flags. An output stall holds the result and
// backs up into in_stall once the input register is also full.
module key_press_duration_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [kpdc_pkg::NUM_KEYS-1:0] pin_levels,
  input  logic [kpdc_pkg::NUM_KEYS-1:0] clear_keys,
  input  logic [1:0]                    clear_types,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kpdc_pkg::NUM_KEYS-1:0] short_flags,
  output logic [kpdc_pkg::NUM_KEYS-1:0] long_flags,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpdc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [kpdc_pkg::CFG_BITS-1:0] cfg_data
);
  import kpdc_pkg::*;
  `include "assert_macros.svh"

  logic                s1_valid;
  logic                s1_action;
  logic [NUM_KEYS-1:0] s1_levels;
  logic [NUM_KEYS-1:0] s1_keys;
  logic [1:0]          s1_types;
  logic                s1_adv;
  logic                out_valid_q;
  window_cfg_t         win;
  key_ctrl_t           ctrl;

  assign s1_adv   = s1_valid && (!out_valid_q || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        s1_valid <= 1'b1;
      else if (s1_adv)
        s1_valid <= 1'b0;
      if (s1_adv)
        out_valid_q <= 1'b1;
      else if (!out_stall)
        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_levels <= pin_levels;
      s1_keys   <= clear_keys;
      s1_types  <= clear_types;
    end
  end

  assign ctrl.upd         = s1_adv;
  assign ctrl.action      = s1_action;
  assign ctrl.clear_types = s1_types;

  kpdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kpdc_key u_key (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .level      (s1_levels[k]),
      .clr_sel    (s1_keys[k]),
      .win        (win),
      .short_flag (short_flags[k]),
      .long_flag  (long_flags[k])
    );
  end

  assign out_valid = out_valid_q;

  `KPDC_ASSERT_IMP(a_stall_needs_item, clk, rst, in_stall, s1_valid && out_valid_q)
  `KPDC_ASSERT_NXT(a_adv_gives_result, clk, rst, s1_adv, out_valid_q)
  `KPDC_ASSERT_NXT(a_flags_hold_stalled, clk, rst, out_valid_q && out_stall,
                   $stable(short_flags) && $stable(long_flags))

endmodule

// ----- tb/sv/tb_key_press_duration_classifier_unit.sv -----
// Self-checking testbench for key_press_duration_classifier_unit: directed and random
// tick/clear requests under idle and stall patterns, flags checked against a predictor.
// Depends on kpdc_pkg and the RTL of the block.
module tb_key_press_duration_classifier_unit;
  import kpdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 295;
  localparam int MAX_PRINTS  = 50;

  localparam logic [1:0] CLEAR_NONE  = 2'b00;
  localparam logic [1:0] CLEAR_SHORT = 2'(1 << CLR_SHORT);
  localparam logic [1:0] CLEAR_LONG  = 2'(1 << CLR_LONG);
  localparam logic [1:0] CLEAR_BOTH  = CLEAR_SHORT | CLEAR_LONG;

  typedef struct {
    logic [NUM_KEYS-1:0] short_f;
    logic [NUM_KEYS-1:0] long_f;
    int                  seq;
  } flag_pair_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                action = ACT_TICK;
  logic [NUM_KEYS-1:0] pin_levels = '1;
  logic [NUM_KEYS-1:0] clear_keys = '0;
  logic [1:0]          clear_types = CLEAR_NONE;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [NUM_KEYS-1:0] short_flags;
  logic [NUM_KEYS-1:0] long_flags;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = REG_SHORT_LOW;
  logic [CFG_BITS-1:0] cfg_data = '0;

  key_press_duration_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .pin_levels (pin_levels),
    .clear_keys (clear_keys),
    .clear_types(clear_types),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .short_flags(short_flags),
    .long_flags (long_flags),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [NUM_KEYS-1:0] key_was_up;
  logic [NUM_KEYS-1:0] short_set;
  logic [NUM_KEYS-1:0] long_set;
  count_t              short_ticks [NUM_KEYS];
  count_t              long_ticks [NUM_KEYS];
  count_t              bound_short_low, bound_short_high, bound_long_low, bound_long_high;

  flag_pair_t flags_due[$];
  int accepted = 0;
  int mismatches = 0;
  int cycle_count = 0;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // per-key press pattern generator
  logic [NUM_KEYS-1:0] gen_level = '1;
  int                  gen_left [NUM_KEYS];

  task automatic predict_flags(input logic act, input logic [NUM_KEYS-1:0] lv,
                               input logic [NUM_KEYS-1:0] ck, input logic [1:0] ct,
                               output logic [NUM_KEYS-1:0] sf, output logic [NUM_KEYS-1:0] lf);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (act == ACT_TICK) begin
        if (lv[k] && !key_was_up[k]) begin
          if (bound_short_low < short_ticks[k] && short_ticks[k] < bound_short_high &&
              !long_set[k])
            short_set[k] = 1'b1;
          short_ticks[k] = '0;
        end else if (!lv[k] && key_was_up[k]) begin
          short_ticks[k] = '0;
        end else if (!lv[k] && !key_was_up[k]) begin
          if (short_ticks[k] != COUNT_MAX) short_ticks[k] = short_ticks[k] + 1'b1;
          if (long_ticks[k] != COUNT_MAX) long_ticks[k] = long_ticks[k] + 1'b1;
          if (bound_long_low < long_ticks[k] && long_ticks[k] < bound_long_high &&
              !short_set[k]) begin
            long_set[k] = 1'b1;
            long_ticks[k] = '0;
          end
        end else begin
          short_ticks[k] = '0;
          long_ticks[k] = '0;
        end
        key_was_up[k] = lv[k];
      end else if (ck[k]) begin
        if (ct[CLR_SHORT]) begin
          short_set[k] = 1'b0;
          short_ticks[k] = '0;
          key_was_up[k] = 1'b1;
        end
        if (ct[CLR_LONG]) begin
          long_set[k] = 1'b0;
          long_ticks[k] = '0;
        end
      end
    end
    sf = short_set;
    lf = long_set;
  endtask

  task automatic report_mismatch(input string what, input int seq,
                                 input logic [NUM_KEYS-1:0] got,
                                 input logic [NUM_KEYS-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH %s request %0d: got %b want %b", what, seq, got, want);
  endtask

  task automatic send_request(input logic act, input logic [NUM_KEYS-1:0] lv,
                              input logic [NUM_KEYS-1:0] ck, input logic [1:0] ct);
    flag_pair_t want;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    pin_levels <= lv;
    clear_keys <= ck;
    clear_types <= ct;
    do @(posedge clk); while (in_stall);
    predict_flags(act, lv, ck, ct, want.short_f, want.long_f);
    want.seq = accepted;
    accepted++;
    flags_due.push_back(want);
  endtask

  task automatic tick(input logic [NUM_KEYS-1:0] lv);
    send_request(ACT_TICK, lv, NUM_KEYS'($urandom_range(7)), 2'($urandom_range(3)));
  endtask

  task automatic clear_flags(input logic [NUM_KEYS-1:0] ck, input logic [1:0] ct);
    send_request(ACT_CLEAR, NUM_KEYS'($urandom_range(7)), ck, ct);
  endtask

  // drop the request line and wait until every flag result is back
  task automatic drain_flags();
    @(negedge clk);
    in_valid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input count_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHORT_LOW:  bound_short_low = val;
      REG_SHORT_HIGH: bound_short_high = val;
      REG_LONG_LOW:   bound_long_low = val;
      default:        bound_long_high = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_windows(input count_t sl, input count_t sh, input count_t ll,
                             input count_t lh);
    drain_flags();
    write_reg(REG_SHORT_LOW, sl);
    write_reg(REG_SHORT_HIGH, sh);
    write_reg(REG_LONG_LOW, ll);
    write_reg(REG_LONG_HIGH, lh);
  endtask

  task automatic next_levels(output logic [NUM_KEYS-1:0] lv);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (gen_left[k] <= 0) begin
        gen_level[k] = ~gen_level[k];
        gen_left[k] = ($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(60, 13);
      end
      gen_left[k]--;
    end
    lv = gen_level;
  endtask

  // mostly press/release patterns; some clears and scrambled levels as noise
  task automatic run_random_items(input int count);
    int r;
    logic [NUM_KEYS-1:0] lv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 2) drain_flags();
      r = $urandom_range(99);
      if (r < 8) begin
        clear_flags(NUM_KEYS'($urandom_range(7)), 2'($urandom_range(3)));
      end else if (r < 13) begin
        tick(NUM_KEYS'($urandom_range(7)));
      end else begin
        next_levels(lv);
        tick(lv);
      end
    end
  endtask

  task automatic test_directed();
    // reset windows: a press held for four ticks is short
    tick(3'b111);
    tick(3'b110);
    tick(3'b110);
    tick(3'b110);
    tick(3'b110);
    tick(3'b111);
    clear_flags(3'b111, CLEAR_BOTH);
    set_windows(16'd1, 16'd4, 16'd4, 16'd6);
    // key 0 short press
    tick(3'b110);
    tick(3'b110);
    tick(3'b110);
    tick(3'b111);
    // key 1 held through the long window, then released too late for short
    tick(3'b101);
    for (int i = 0; i < 5; i++) tick(3'b101);
    tick(3'b111);
    // short clear on a held key makes the next tick a fresh press
    tick(3'b011);
    tick(3'b011);
    clear_flags(3'b100, CLEAR_SHORT);
    tick(3'b011);
    clear_flags(3'b111, CLEAR_NONE);
    clear_flags(3'b011, CLEAR_LONG);
    clear_flags(3'b111, CLEAR_BOTH);
    // press and release on the next tick: count zero
    tick(3'b000);
    tick(3'b111);
  endtask

  task automatic test_window_extremes();
    set_windows(16'd0, 16'd0, 16'd0, 16'd0);
    run_random_items(40);
    set_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_random_items(40);
    set_windows(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    run_random_items(40);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      set_windows(count_t'($urandom_range(6)), count_t'($urandom_range(24)),
                  count_t'($urandom_range(16)), count_t'($urandom_range(32)));
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 56; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 56; end
        default: begin sender_idle_pct = 19; stall_pct = 19; end
      endcase
      run_random_items(PHASE_ITEMS);
    end
    sender_idle_pct = 0;
    stall_pct = 0;
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    set_windows(16'd2, 16'd10, 16'd5, 16'd12);
    hold_requests++;
    run_random_items(40);
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    flag_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (flags_due.size() == 0) begin
        report_mismatch("unexpected result", -1, short_flags, '0);
      end else begin
        want = flags_due.pop_front();
        if (short_flags !== want.short_f)
          report_mismatch("short_flags", want.seq, short_flags, want.short_f);
        if (long_flags !== want.long_f)
          report_mismatch("long_flags", want.seq, long_flags, want.long_f);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_key_press_duration_classifier_unit NOT OK");
      $finish;
    end
  end

  initial begin
    key_was_up = '1;
    short_set = '0;
    long_set = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      short_ticks[k] = '0;
      long_ticks[k] = '0;
      gen_left[k] = 0;
    end
    bound_short_low = 16'd2;
    bound_short_high = 16'd500;
    bound_long_low = 16'd1000;
    bound_long_high = 16'd1100;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_window_extremes();
    test_random_phases();
    test_backpressure();
    drain_flags();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && flags_due.size() == 0)
      $display("tb_key_press_duration_classifier_unit OK");
    else
      $display("tb_key_press_duration_classifier_unit NOT OK");
    $finish;
  end

endmodule
